// ===== rtl/hlu_pkg.sv =====
package hlu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SEL_W = 3;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned HOLDER_W = 2;
  localparam int unsigned TAG_W = 4;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [SEL_W-1:0] SEL_CORE_STATUS = 3'd0;
  localparam logic [SEL_W-1:0] SEL_APP_REQUEST = 3'd1;
  localparam logic [SEL_W-1:0] SEL_APP_RELEASE = 3'd2;
  localparam logic [SEL_W-1:0] SEL_EXCLUSIVE = 3'd3;
  localparam logic [SEL_W-1:0] SEL_MCU_REQUEST = 3'd4;
  localparam logic [SEL_W-1:0] SEL_MCU_RELEASE = 3'd5;

  localparam logic [HOLDER_W-1:0] HOLDER_IDLE = 2'd0;
  localparam logic [HOLDER_W-1:0] HOLDER_APP = 2'd1;
  localparam logic [HOLDER_W-1:0] HOLDER_MCU = 2'd2;

  localparam logic [TAG_W-1:0] TAG_IDLE = 4'h0;
  localparam logic [TAG_W-1:0] TAG_KEEP = 4'hF;

  typedef struct packed {
    logic [DATA_W-1:0] write_data;
    logic [SEL_W-1:0] reg_select;
    logic op;
  } hlu_cmd_t;

endpackage

// ===== rtl/hlu_lock_core.sv =====
module hlu_lock_core #(
  parameter int unsigned NUM_CORE_LOCKS = 16,
  parameter int unsigned NUM_EXCL_LOCKS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_en,
  input  hlu_pkg::hlu_cmd_t cmd,
  output logic [hlu_pkg::DATA_W-1:0] rd_data
);

  logic [hlu_pkg::HOLDER_W-1:0] holder_r [NUM_CORE_LOCKS];
  logic [hlu_pkg::HOLDER_W-1:0] holder_nxt [NUM_CORE_LOCKS];
  logic [hlu_pkg::TAG_W-1:0] tag_r [NUM_EXCL_LOCKS];
  logic [hlu_pkg::TAG_W-1:0] tag_nxt [NUM_EXCL_LOCKS];

  always_comb begin
    logic [hlu_pkg::TAG_W-1:0] code;
    code = hlu_pkg::TAG_IDLE;
    for (int i = 0; i < NUM_CORE_LOCKS; i++) begin
      holder_nxt[i] = holder_r[i];
    end
    for (int j = 0; j < NUM_EXCL_LOCKS; j++) begin
      tag_nxt[j] = tag_r[j];
    end
    rd_data = '0;
    if (cmd.op == hlu_pkg::OP_READ) begin
      unique case (cmd.reg_select)
        hlu_pkg::SEL_CORE_STATUS: begin
          for (int i = 0; i < NUM_CORE_LOCKS; i++) begin
            rd_data[hlu_pkg::HOLDER_W*i +: hlu_pkg::HOLDER_W] = holder_r[i];
          end
        end
        hlu_pkg::SEL_EXCLUSIVE: begin
          for (int j = 0; j < NUM_EXCL_LOCKS; j++) begin
            rd_data[hlu_pkg::TAG_W*j +: hlu_pkg::TAG_W] = tag_r[j];
          end
        end
        default: rd_data = '0;
      endcase
    end else begin
      unique case (cmd.reg_select)
        hlu_pkg::SEL_APP_REQUEST: begin
          for (int i = 0; i < NUM_CORE_LOCKS; i++) begin
            if (cmd.write_data[i] && holder_r[i] == hlu_pkg::HOLDER_IDLE) begin
              holder_nxt[i] = hlu_pkg::HOLDER_APP;
            end
          end
        end
        hlu_pkg::SEL_MCU_REQUEST: begin
          for (int i = 0; i < NUM_CORE_LOCKS; i++) begin
            if (cmd.write_data[i] && holder_r[i] == hlu_pkg::HOLDER_IDLE) begin
              holder_nxt[i] = hlu_pkg::HOLDER_MCU;
            end
          end
        end
        hlu_pkg::SEL_APP_RELEASE: begin
          for (int i = 0; i < NUM_CORE_LOCKS; i++) begin
            if (cmd.write_data[i] && holder_r[i] == hlu_pkg::HOLDER_APP) begin
              holder_nxt[i] = hlu_pkg::HOLDER_IDLE;
            end
          end
        end
        hlu_pkg::SEL_MCU_RELEASE: begin
          for (int i = 0; i < NUM_CORE_LOCKS; i++) begin
            if (cmd.write_data[i] && holder_r[i] == hlu_pkg::HOLDER_MCU) begin
              holder_nxt[i] = hlu_pkg::HOLDER_IDLE;
            end
          end
        end
        hlu_pkg::SEL_EXCLUSIVE: begin
          for (int j = 0; j < NUM_EXCL_LOCKS; j++) begin
            code = cmd.write_data[hlu_pkg::TAG_W*j +: hlu_pkg::TAG_W];
            if (code == hlu_pkg::TAG_IDLE) begin
              tag_nxt[j] = hlu_pkg::TAG_IDLE;
            end else if (code != hlu_pkg::TAG_KEEP && tag_r[j] == hlu_pkg::TAG_IDLE) begin
              tag_nxt[j] = code;
            end
          end
        end
        default: rd_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CORE_LOCKS; i++) begin
        holder_r[i] <= hlu_pkg::HOLDER_IDLE;
      end
      for (int j = 0; j < NUM_EXCL_LOCKS; j++) begin
        tag_r[j] <= hlu_pkg::TAG_IDLE;
      end
    end else if (cmd_en) begin
      holder_r <= holder_nxt;
      tag_r <= tag_nxt;
    end
  end

endmodule

// ===== rtl/hardware_lock_unit.sv =====
// Channel | Port group            | Fields (lowest bit first)
// in      | in_tvalid/tready/data | op[0], reg_select[3:1], write_data[35:4]
// out     | out_tvalid/tready/data| read_data[31:0]
// Takes one item per cycle unless output stalls; out_tvalid comes from the result register.
// Items pass an input register, then the lock state update and result register.
// Reset clears both valid flags and sets every lock to idle.
// A stalled output holds its result and the input register; in_tready falls
// only when both stages are full and out_tready is low.
module hardware_lock_unit #(
  parameter int unsigned NUM_CORE_LOCKS = 16,
  parameter int unsigned NUM_EXCL_LOCKS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [hlu_pkg::IN_TDATA_W-1:0] in_tdata, // op, reg_select, write_data, zero pad
  output logic out_tvalid,
  input  logic out_tready,
  output logic [hlu_pkg::DATA_W-1:0] out_tdata // read_data
);

  logic in_valid_r;
  hlu_pkg::hlu_cmd_t in_cmd_r;
  logic out_valid_r;
  logic [hlu_pkg::DATA_W-1:0] out_data_r;
  logic advance;
  logic [hlu_pkg::DATA_W-1:0] rd_data;

  assign advance = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  hlu_lock_core #(
    .NUM_CORE_LOCKS(NUM_CORE_LOCKS),
    .NUM_EXCL_LOCKS(NUM_EXCL_LOCKS)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_en(advance),
    .cmd(in_cmd_r),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r <= in_tdata[$bits(hlu_pkg::hlu_cmd_t)-1:0];
    end
    if (advance) begin
      out_data_r <= rd_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule
